// File: rtl/ddwi_pkg.sv
// ============================================================================
// ddwi_pkg: shared types and constants of the dedispersion window indexer
// Holds the state encodings, micro-operation codes, register indexes and
// the fixed arithmetic constants used by the delay unit and the top level.
// ============================================================================
package ddwi_pkg;

    // 4150 * 64 * 10^6, dispersion constant with the unit scalings folded in
    localparam logic [37:0] DELAY_K = 38'd265600000000;

    localparam logic [31:0] S32_MAX = 32'h7FFF_FFFF;
    localparam logic [31:0] S32_MIN = 32'h8000_0000;
    localparam logic [44:0] SUM_MAX = {45{1'b1}};
    localparam logic [43:0] TOT_MAX = {44{1'b1}};

    localparam logic [23:0] DM_RESET    = 24'd0;
    localparam logic [23:0] REF_RESET   = 24'd25600;
    localparam logic [23:0] TSTEP_RESET = 24'd1000;

    typedef enum logic [1:0] {
        REG_DM    = 2'd0,
        REG_REF   = 2'd1,
        REG_TSTEP = 2'd2
    } cfg_reg_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_DLY,
        S_EMIT
    } top_state_t;

    typedef enum logic [2:0] {
        D_IDLE,
        D_LOAD,
        D_MUL,
        D_CHECK,
        D_DIV,
        D_FIN
    } dly_state_t;

    // Products formed in order by the shared digit-serial multiplier
    typedef enum logic [2:0] {
        OP_F2,
        OP_R2,
        OP_T1,
        OP_NUM,
        OP_P,
        OP_DEN
    } dly_op_t;

endpackage

// File: rtl/ddwi_delay_unit.sv
// ============================================================================
// ddwi_delay_unit: channel delay in time bins
// Forms numerator and denominator with one 8-bit-digit serial multiplier,
// then runs a radix-2 restoring divider with 32-bit signed saturation.
// ============================================================================
module ddwi_delay_unit
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic [24:0]        freq,
    input  logic [23:0]        dm,
    input  logic [23:0]        ref_freq,
    input  logic [23:0]        time_step_us,
    output logic               done,
    output logic signed [31:0] result
);

    ddwi_pkg::dly_state_t state_reg, state_next;
    ddwi_pkg::dly_op_t    op_reg, op_next;
    logic [5:0]           cnt_reg, cnt_next;

    logic [24:0]  f_reg, f_next;
    logic [97:0]  a_reg, a_next;
    logic [55:0]  b_reg, b_next;
    logic [121:0] acc_reg, acc_next;
    logic [49:0]  f2_reg, f2_next;
    logic [47:0]  r2_reg, r2_next;
    logic [61:0]  t1_reg, t1_next;
    logic [112:0] num_reg, num_next;
    logic [97:0]  p_reg, p_next;
    logic [121:0] den_reg, den_next;
    logic [153:0] d_reg, d_next;
    logic [32:0]  q_reg, q_next;
    logic         neg_reg, neg_next;
    logic         ovf_reg, ovf_next;
    logic         zero_reg, zero_next;

    logic [105:0] prod;
    logic [121:0] acc_step;
    logic [49:0]  diff;
    logic         r2_lt;
    logic         ovf_cmp;
    logic         ge;

    assign prod     = a_reg * b_reg[55:48];
    assign acc_step = {acc_reg[113:0], 8'd0} + {16'd0, prod};
    assign r2_lt    = {2'd0, r2_reg} < f2_reg;
    assign diff     = r2_lt ? (f2_reg - {2'd0, r2_reg}) : ({2'd0, r2_reg} - f2_reg);
    assign ovf_cmp  = {42'd0, num_reg} >= {den_reg, 33'd0};
    assign ge       = (d_reg[153:113] == '0) && (num_reg >= d_reg[112:0]);

    always_comb
    begin
        state_next = state_reg;
        op_next    = op_reg;
        cnt_next   = cnt_reg;
        f_next     = f_reg;
        a_next     = a_reg;
        b_next     = b_reg;
        acc_next   = acc_reg;
        f2_next    = f2_reg;
        r2_next    = r2_reg;
        t1_next    = t1_reg;
        num_next   = num_reg;
        p_next     = p_reg;
        den_next   = den_reg;
        d_next     = d_reg;
        q_next     = q_reg;
        neg_next   = neg_reg;
        ovf_next   = ovf_reg;
        zero_next  = zero_reg;
        done       = 1'b0;
        result     = '0;

        unique case (state_reg)
            ddwi_pkg::D_IDLE:
            begin
                if (start)
                begin
                    f_next     = freq;
                    op_next    = ddwi_pkg::OP_F2;
                    state_next = ddwi_pkg::D_LOAD;
                end
            end
            ddwi_pkg::D_LOAD:
            begin
                // Align each second operand so its top digit sits in the top byte of b
                acc_next   = '0;
                state_next = ddwi_pkg::D_MUL;
                unique case (op_reg)
                    ddwi_pkg::OP_F2:
                    begin
                        a_next   = {73'd0, f_reg};
                        b_next   = {7'd0, f_reg, 24'd0};
                        cnt_next = 6'd4;
                    end
                    ddwi_pkg::OP_R2:
                    begin
                        a_next   = {74'd0, ref_freq};
                        b_next   = {ref_freq, 32'd0};
                        cnt_next = 6'd3;
                    end
                    ddwi_pkg::OP_T1:
                    begin
                        a_next   = {60'd0, ddwi_pkg::DELAY_K};
                        b_next   = {dm, 32'd0};
                        cnt_next = 6'd3;
                    end
                    ddwi_pkg::OP_NUM:
                    begin
                        neg_next = r2_lt;
                        a_next   = {36'd0, t1_reg};
                        b_next   = {6'd0, diff};
                        cnt_next = 6'd7;
                    end
                    ddwi_pkg::OP_P:
                    begin
                        a_next   = {48'd0, f2_reg};
                        b_next   = {r2_reg, 8'd0};
                        cnt_next = 6'd6;
                    end
                    ddwi_pkg::OP_DEN:
                    begin
                        a_next   = p_reg;
                        b_next   = {time_step_us, 32'd0};
                        cnt_next = 6'd3;
                    end
                    default:
                    begin
                        cnt_next = 6'd1;
                    end
                endcase
            end
            ddwi_pkg::D_MUL:
            begin
                acc_next = acc_step;
                b_next   = {b_reg[47:0], 8'd0};
                cnt_next = cnt_reg - 6'd1;
                if (cnt_reg == 6'd1)
                begin
                    state_next = ddwi_pkg::D_LOAD;
                    unique case (op_reg)
                        ddwi_pkg::OP_F2:
                        begin
                            f2_next = acc_step[49:0];
                            op_next = ddwi_pkg::OP_R2;
                        end
                        ddwi_pkg::OP_R2:
                        begin
                            r2_next = acc_step[47:0];
                            op_next = ddwi_pkg::OP_T1;
                        end
                        ddwi_pkg::OP_T1:
                        begin
                            t1_next = acc_step[61:0];
                            op_next = ddwi_pkg::OP_NUM;
                        end
                        ddwi_pkg::OP_NUM:
                        begin
                            num_next = acc_step[112:0];
                            op_next  = ddwi_pkg::OP_P;
                        end
                        ddwi_pkg::OP_P:
                        begin
                            p_next  = acc_step[97:0];
                            op_next = ddwi_pkg::OP_DEN;
                        end
                        default:
                        begin
                            den_next   = acc_step;
                            state_next = ddwi_pkg::D_CHECK;
                        end
                    endcase
                end
            end
            ddwi_pkg::D_CHECK:
            begin
                zero_next = 1'b0;
                ovf_next  = 1'b0;
                if (num_reg == '0)
                begin
                    zero_next  = 1'b1;
                    state_next = ddwi_pkg::D_FIN;
                end
                else if (ovf_cmp)
                begin
                    // Covers a zero denominator as well
                    ovf_next   = 1'b1;
                    state_next = ddwi_pkg::D_FIN;
                end
                else
                begin
                    d_next     = {den_reg, 32'd0};
                    q_next     = '0;
                    cnt_next   = 6'd33;
                    state_next = ddwi_pkg::D_DIV;
                end
            end
            ddwi_pkg::D_DIV:
            begin
                if (ge)
                begin
                    num_next = num_reg - d_reg[112:0];
                end
                q_next   = {q_reg[31:0], ge};
                d_next   = {1'b0, d_reg[153:1]};
                cnt_next = cnt_reg - 6'd1;
                if (cnt_reg == 6'd1)
                begin
                    state_next = ddwi_pkg::D_FIN;
                end
            end
            ddwi_pkg::D_FIN:
            begin
                done       = 1'b1;
                state_next = ddwi_pkg::D_IDLE;
                if (zero_reg)
                begin
                    result = '0;
                end
                else if (ovf_reg)
                begin
                    result = neg_reg ? ddwi_pkg::S32_MIN : ddwi_pkg::S32_MAX;
                end
                else if (neg_reg)
                begin
                    result = (q_reg > 33'h0_8000_0000) ? ddwi_pkg::S32_MIN
                                                       : (~q_reg[31:0] + 32'd1);
                end
                else
                begin
                    result = (q_reg > 33'h0_7FFF_FFFF) ? ddwi_pkg::S32_MAX : q_reg[31:0];
                end
            end
            default:
            begin
                state_next = ddwi_pkg::D_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ddwi_pkg::D_IDLE;
            op_reg    <= ddwi_pkg::OP_F2;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            op_reg    <= op_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        f_reg    <= f_next;
        a_reg    <= a_next;
        b_reg    <= b_next;
        acc_reg  <= acc_next;
        f2_reg   <= f2_next;
        r2_reg   <= r2_next;
        t1_reg   <= t1_next;
        num_reg  <= num_next;
        p_reg    <= p_next;
        den_reg  <= den_next;
        d_reg    <= d_next;
        q_reg    <= q_next;
        neg_reg  <= neg_next;
        ovf_reg  <= ovf_next;
        zero_reg <= zero_next;
    end

endmodule

// File: rtl/dispersion_delay_window_indexer.sv
// ============================================================================
// dispersion_delay_window_indexer: dedispersion time-bin window per channel
// Takes channel frequencies of a sweep and returns each channel's select
// window (start, end) and the running total of window widths.
// ============================================================================
// Steps: the delay unit runs 6 operand loads, 26 multiplier digits, 1 range check,
//   33 divider steps and 1 finish; the window step then registers the item. A zero
//   numerator or an out-of-range quotient skips the divider.
// Flow: a new channel is taken only after the previous item is loaded for output;
//   channel 0 of a longer sweep gives no item and frees the input once its delay is
//   known. Channel 1 runs the delay unit twice (imaginary channel, then its own) for
//   its two items. A stalled output holds the window step, and in_stall stays high
//   until it moves.
// Reset: asynchronous, active low; clears the sweep state and loads the
//   register defaults (dm 0, ref_freq 25600, time_step_us 1000).
module dispersion_delay_window_indexer
#(
    parameter int MAX_CHANNELS = 4096
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_wr_en,
    input  logic [1:0]         cfg_index,
    input  logic [23:0]        cfg_data,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [23:0]        channel_freq,
    input  logic               last_channel,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [11:0]        channel_number,
    output logic signed [31:0] start_index,
    output logic signed [31:0] end_index,
    output logic [43:0]        window_total,
    output logic               last
);

    localparam int CW = $clog2(MAX_CHANNELS + 1);
    localparam logic [CW-1:0] MAX_CNT = CW'(MAX_CHANNELS);

    // Configuration registers
    logic [23:0] dm_reg, ref_reg, tstep_reg;

    ddwi_pkg::top_state_t state_reg, state_next;
    logic [CW-1:0] count_reg, count_next;
    logic [44:0]   width_sum_reg, width_sum_next;
    logic          imag_reg, imag_next;
    logic          restart_reg, restart_next;
    logic          out_valid_reg, out_valid_next;

    logic [23:0]        first_freq_reg, first_freq_next;
    logic signed [31:0] first_start_reg, first_start_next;
    logic signed [31:0] prev_start_reg, prev_start_next;
    logic [23:0]        freq_reg, freq_next;
    logic               lastc_reg, lastc_next;
    logic [11:0]        em_chan_reg, em_chan_next;
    logic signed [31:0] em_start_reg, em_start_next;
    logic signed [31:0] em_before_reg, em_before_next;
    logic               em_last_reg, em_last_next;
    logic [11:0]        o_chan_reg, o_chan_next;
    logic signed [31:0] o_start_reg, o_start_next;
    logic signed [31:0] o_end_reg, o_end_next;
    logic [43:0]        o_total_reg, o_total_next;
    logic               o_last_reg, o_last_next;

    logic               in_acc;
    logic               out_load;
    logic               dly_start;
    logic [24:0]        dly_freq;
    logic               dly_done;
    logic signed [31:0] dly_result;

    logic [25:0]        imag_c0;
    logic [24:0]        imag_mag;
    logic signed [32:0] before_m1;
    logic               gap;
    logic signed [31:0] win_end;
    logic [32:0]        win_width;
    logic [45:0]        sum_raw;
    logic [44:0]        sum_sat;
    logic [CW-1:0]      chan_sat;

    ddwi_delay_unit u_delay
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (dly_start),
        .freq         (dly_freq),
        .dm           (dm_reg),
        .ref_freq     (ref_reg),
        .time_step_us (tstep_reg),
        .done         (dly_done),
        .result       (dly_result)
    );

    assign in_stall  = (state_reg != ddwi_pkg::S_IDLE);
    assign in_acc    = in_valid && !in_stall;
    assign out_load  = (state_reg == ddwi_pkg::S_EMIT) && (!out_valid_reg || !out_stall);

    // Imaginary channel 2*f0 - f1; only its magnitude matters
    assign imag_c0  = {1'b0, first_freq_reg, 1'b0} - {2'b0, channel_freq};
    assign imag_mag = imag_c0[25] ? 25'(~imag_c0 + 26'd1) : imag_c0[24:0];

    // Window: end is before-1 when that lies past start, else start itself
    assign before_m1 = {em_before_reg[31], em_before_reg} - 33'sd1;
    assign gap       = before_m1 > $signed({em_start_reg[31], em_start_reg});
    assign win_end   = gap ? before_m1[31:0] : em_start_reg;
    assign win_width = {win_end[31], win_end} - {em_start_reg[31], em_start_reg} + 33'd1;
    assign sum_raw   = {1'b0, width_sum_reg} + {13'd0, win_width};
    assign sum_sat   = (sum_raw > {1'b0, ddwi_pkg::SUM_MAX}) ? ddwi_pkg::SUM_MAX
                                                            : sum_raw[44:0];

    // Channel number holds at the top once the sweep runs long
    assign chan_sat = (count_reg < MAX_CNT) ? count_reg : (MAX_CNT - CW'(1));

    always_comb
    begin
        state_next       = state_reg;
        count_next       = count_reg;
        width_sum_next   = width_sum_reg;
        imag_next        = imag_reg;
        restart_next     = restart_reg;
        out_valid_next   = out_valid_reg;
        first_freq_next  = first_freq_reg;
        first_start_next = first_start_reg;
        prev_start_next  = prev_start_reg;
        freq_next        = freq_reg;
        lastc_next       = lastc_reg;
        em_chan_next     = em_chan_reg;
        em_start_next    = em_start_reg;
        em_before_next   = em_before_reg;
        em_last_next     = em_last_reg;
        o_chan_next      = o_chan_reg;
        o_start_next     = o_start_reg;
        o_end_next       = o_end_reg;
        o_total_next     = o_total_reg;
        o_last_next      = o_last_reg;
        dly_start        = 1'b0;
        dly_freq         = {1'b0, channel_freq};

        // Drop the output item once taken
        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ddwi_pkg::S_IDLE:
            begin
                if (in_acc)
                begin
                    freq_next  = channel_freq;
                    lastc_next = last_channel;
                    dly_start  = 1'b1;
                    // Channel 1 first resolves channel 0's imaginary neighbor
                    if (count_reg == CW'(1))
                    begin
                        imag_next = 1'b1;
                        dly_freq  = imag_mag;
                    end
                    else
                    begin
                        imag_next = 1'b0;
                    end
                    state_next = ddwi_pkg::S_DLY;
                end
            end
            ddwi_pkg::S_DLY:
            begin
                if (dly_done)
                begin
                    state_next = ddwi_pkg::S_EMIT;
                    if (imag_reg)
                    begin
                        // Release the held channel 0 item
                        em_chan_next   = 12'd0;
                        em_start_next  = first_start_reg;
                        em_before_next = dly_result;
                        em_last_next   = 1'b0;
                        imag_next      = 1'b0;
                        restart_next   = 1'b1;
                    end
                    else if (count_reg == '0)
                    begin
                        first_freq_next  = freq_reg;
                        first_start_next = dly_result;
                        prev_start_next  = dly_result;
                        count_next       = CW'(1);
                        em_chan_next     = 12'd0;
                        em_start_next    = dly_result;
                        em_before_next   = dly_result;
                        em_last_next     = 1'b1;
                        // Hold channel 0 unless the sweep ends here
                        if (!lastc_reg)
                        begin
                            state_next = ddwi_pkg::S_IDLE;
                        end
                    end
                    else if (count_reg == CW'(1))
                    begin
                        em_chan_next    = 12'd1;
                        em_start_next   = dly_result;
                        em_before_next  = first_start_reg;
                        em_last_next    = lastc_reg;
                        prev_start_next = dly_result;
                        count_next      = CW'(2);
                    end
                    else
                    begin
                        em_chan_next    = 12'(chan_sat);
                        em_start_next   = dly_result;
                        em_before_next  = prev_start_reg;
                        em_last_next    = lastc_reg;
                        prev_start_next = dly_result;
                        if (count_reg < MAX_CNT)
                        begin
                            count_next = count_reg + CW'(1);
                        end
                    end
                end
            end
            ddwi_pkg::S_EMIT:
            begin
                if (out_load)
                begin
                    out_valid_next = 1'b1;
                    o_chan_next    = em_chan_reg;
                    o_start_next   = em_start_reg;
                    o_end_next     = win_end;
                    o_total_next   = (sum_sat > {1'b0, ddwi_pkg::TOT_MAX}) ? ddwi_pkg::TOT_MAX
                                                                         : sum_sat[43:0];
                    o_last_next    = em_last_reg;
                    width_sum_next = sum_sat;
                    if (restart_reg)
                    begin
                        // Advance to channel 1's own delay
                        restart_next = 1'b0;
                        dly_start    = 1'b1;
                        dly_freq     = {1'b0, freq_reg};
                        state_next   = ddwi_pkg::S_DLY;
                    end
                    else
                    begin
                        if (em_last_reg)
                        begin
                            count_next     = '0;
                            width_sum_next = '0;
                        end
                        state_next = ddwi_pkg::S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ddwi_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ddwi_pkg::S_IDLE;
            count_reg       <= '0;
            width_sum_reg   <= '0;
            imag_reg        <= 1'b0;
            restart_reg     <= 1'b0;
            out_valid_reg   <= 1'b0;
            first_freq_reg  <= '0;
            first_start_reg <= '0;
            prev_start_reg  <= '0;
            dm_reg          <= ddwi_pkg::DM_RESET;
            ref_reg         <= ddwi_pkg::REF_RESET;
            tstep_reg       <= ddwi_pkg::TSTEP_RESET;
        end
        else
        begin
            state_reg       <= state_next;
            count_reg       <= count_next;
            width_sum_reg   <= width_sum_next;
            imag_reg        <= imag_next;
            restart_reg     <= restart_next;
            out_valid_reg   <= out_valid_next;
            first_freq_reg  <= first_freq_next;
            first_start_reg <= first_start_next;
            prev_start_reg  <= prev_start_next;
            if (cfg_wr_en)
            begin
                unique case (cfg_index)
                    ddwi_pkg::REG_DM:    dm_reg    <= cfg_data;
                    ddwi_pkg::REG_REF:   ref_reg   <= cfg_data;
                    ddwi_pkg::REG_TSTEP: tstep_reg <= cfg_data;
                    default:
                    begin
                        dm_reg <= dm_reg;
                    end
                endcase
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        freq_reg      <= freq_next;
        lastc_reg     <= lastc_next;
        em_chan_reg   <= em_chan_next;
        em_start_reg  <= em_start_next;
        em_before_reg <= em_before_next;
        em_last_reg   <= em_last_next;
        o_chan_reg    <= o_chan_next;
        o_start_reg   <= o_start_next;
        o_end_reg     <= o_end_next;
        o_total_reg   <= o_total_next;
        o_last_reg    <= o_last_next;
    end

    assign out_valid      = out_valid_reg;
    assign channel_number = o_chan_reg;
    assign start_index    = o_start_reg;
    assign end_index      = o_end_reg;
    assign window_total   = o_total_reg;
    assign last           = o_last_reg;

    // The delay unit only finishes while a channel waits on it
    a_done_in_dly: assert property (@(posedge clk) disable iff (!rst_n)
        dly_done |-> state_reg == ddwi_pkg::S_DLY)
        else $error("delay unit finished outside the delay wait");

    // A window is never empty, so the total is nonzero after a mid-sweep item
    a_sum_grows: assert property (@(posedge clk) disable iff (!rst_n)
        (out_load && !restart_reg && !em_last_reg) |=> width_sum_reg != '0)
        else $error("width total is zero after an item");

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= MAX_CNT)
        else $error("channel count beyond its limit");

    a_end_after_start: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> o_end_reg >= o_start_reg)
        else $error("window end before its start");

endmodule

// File: dv/dispersion_delay_window_indexer_tb.sv
// ----------------------------------------------------------------------------
// Testbench for the dedispersion window indexer
// Drives channel sweeps under random idling and stalls, predicts each window
// with exact integer arithmetic and checks every result field in order.
// ----------------------------------------------------------------------------
module dispersion_delay_window_indexer_tb;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic [11:0] chan;
        logic [31:0] start;
        logic [31:0] stop;
        logic [43:0] total;
        logic        last;
    } window_t;

    // Scoreboard: holds the predictor state and the queue of expected windows.
    class window_scoreboard;
        logic [23:0] dm_val, ref_val, tstep_val;
        logic [23:0] first_freq;
        longint      first_start, prev_start;
        int          chan_count;
        logic [44:0] width_sum;
        window_t     pending[$];
        int          errors, checked;

        function new();
            dm_val = ddwi_pkg::DM_RESET;
            ref_val = ddwi_pkg::REF_RESET;
            tstep_val = ddwi_pkg::TSTEP_RESET;
            first_freq = 0; first_start = 0; prev_start = 0;
            chan_count = 0; width_sum = 0; errors = 0; checked = 0;
        endfunction

        function void write_reg(ddwi_pkg::cfg_reg_t idx, logic [23:0] v);
            case (idx)
                ddwi_pkg::REG_DM:    dm_val = v;
                ddwi_pkg::REG_REF:   ref_val = v;
                ddwi_pkg::REG_TSTEP: tstep_val = v;
                default: ;
            endcase
        endfunction

        // Delay of frequency f in time bins, truncated then saturated.
        function longint delay_bins(logic [24:0] f);
            logic [63:0]  r2, f2, diff;
            logic [127:0] num, den, q;
            bit           neg;
            r2 = 64'(ref_val) * 64'(ref_val);
            f2 = 64'(f) * 64'(f);
            neg = r2 < f2;
            diff = neg ? f2 - r2 : r2 - f2;
            num = 128'(ddwi_pkg::DELAY_K) * 128'(dm_val) * 128'(diff);
            den = 128'(f2) * 128'(r2) * 128'(tstep_val);
            if (num == 0) return 0;
            if (den == 0) return neg ? -64'sd2147483648 : 64'sd2147483647;
            q = num / den;
            if (neg) return (q > 128'd2147483648) ? -64'sd2147483648 : -longint'(q);
            return (q > 128'd2147483647) ? 64'sd2147483647 : longint'(q);
        endfunction

        function void push_window(int chan, longint s, longint prior, bit lst);
            longint  smear, e;
            window_t w;
            smear = prior - s - 1;
            if (smear < 0) smear = 0;
            e = s + smear;
            if (e > 64'sd2147483647) e = 64'sd2147483647;
            if (46'(width_sum) + 46'(e - s + 1) > 46'(ddwi_pkg::SUM_MAX))
                width_sum = ddwi_pkg::SUM_MAX;
            else width_sum = width_sum + 45'(e - s + 1);
            w.chan = chan[11:0];
            w.start = s[31:0];
            w.stop = e[31:0];
            w.total = (width_sum > 45'(ddwi_pkg::TOT_MAX)) ? ddwi_pkg::TOT_MAX
                                                          : width_sum[43:0];
            w.last = lst;
            pending.push_back(w);
        endfunction

        // Note an accepted channel and queue the windows it releases.
        function void note_channel(logic [23:0] f, bit lst);
            longint s, c0, c0s;
            if (chan_count == 0) begin
                s = delay_bins(f);
                first_freq = f; first_start = s; prev_start = s; chan_count = 1;
                if (lst) push_window(0, s, s, 1'b1);
            end else if (chan_count == 1) begin
                c0 = 2 * longint'(first_freq) - longint'(f);
                if (c0 < 0) c0 = -c0;
                c0s = delay_bins(c0[24:0]);
                push_window(0, first_start, c0s, 1'b0);
                s = delay_bins(f);
                push_window(1, s, first_start, lst);
                prev_start = s; chan_count = 2;
            end else begin
                s = delay_bins(f);
                push_window(chan_count < 4096 ? chan_count : 4095, s, prev_start, lst);
                prev_start = s;
                if (chan_count < 4096) chan_count++;
            end
            if (lst) begin
                chan_count = 0;
                width_sum = 0;
            end
        endfunction

        function void check_window(window_t got);
            window_t w;
            checked++;
            if (pending.size() == 0) begin
                $error("unexpected window, channel %0d", got.chan);
                errors++;
                return;
            end
            w = pending.pop_front();
            if (got.chan !== w.chan) begin
                $error("channel_number exp %0d got %0d", w.chan, got.chan); errors++;
            end
            if (got.start !== w.start) begin
                $error("start_index exp %0d got %0d", $signed(w.start), $signed(got.start));
                errors++;
            end
            if (got.stop !== w.stop) begin
                $error("end_index exp %0d got %0d", $signed(w.stop), $signed(got.stop));
                errors++;
            end
            if (got.total !== w.total) begin
                $error("window_total exp %0d got %0d", w.total, got.total); errors++;
            end
            if (got.last !== w.last) begin
                $error("last exp %0d got %0d", w.last, got.last); errors++;
            end
        endfunction
    endclass

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               cfg_wr_en = 1'b0;
    logic [1:0]         cfg_index = '0;
    logic [23:0]        cfg_data = '0;
    logic               in_valid = 1'b0;
    logic               in_stall;
    logic [23:0]        channel_freq = 24'd1;
    logic               last_channel = 1'b0;
    logic               out_valid;
    logic               out_stall = 1'b0;
    logic [11:0]        channel_number;
    logic signed [31:0] start_index;
    logic signed [31:0] end_index;
    logic [43:0]        window_total;
    logic               last;

    window_scoreboard sb = new();
    int  sent = 0;
    int  hold_off = 0;     // long receiver hold-off, in cycles
    bit  busy_idle = 1'b1; // let idling be switched off for some stretches

    always #2 clk = ~clk;

    dispersion_delay_window_indexer i_dut (.*);

    // Drive one register write while the block is idle.
    task automatic write_reg(ddwi_pkg::cfg_reg_t idx, logic [23:0] v);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data <= v;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        sb.write_reg(idx, v);
        @(posedge clk);
    endtask

    // Offer one channel and hold it until the block accepts it.
    task automatic send_channel(logic [23:0] f, bit lst);
        int gap;
        gap = busy_idle ? $urandom_range(0, 10) : 0;
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        channel_freq <= f;
        last_channel <= lst;
        do @(posedge clk); while (in_stall);
        sb.note_channel(f, lst);
        sent++;
    endtask

    // Wait until every expected window has come out, then let the block drain.
    task automatic drain();
        in_valid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge clk);
        repeat (150) @(posedge clk);
    endtask

    function automatic logic [23:0] rand_freq();
        case ($urandom_range(0, 5))
            0: return 24'($urandom_range(1, 24'hFFFFFF));
            1: return 24'($urandom_range(1, 64));
            2: return 24'hFFFFFF - 24'($urandom_range(0, 63));
            default: return 24'($urandom_range(12800, 51200));
        endcase
    endfunction

    // Send one sweep: mostly a descending band around the reference.
    task automatic send_sweep(int n);
        logic [23:0] f;
        int          step;
        f = rand_freq();
        step = $urandom_range(0, 400);
        for (int i = 0; i < n; i++) begin
            send_channel((f == 0) ? 24'd1 : f, i == n - 1);
            if ($urandom_range(0, 9) == 0) f = rand_freq();
            else f = (f > step) ? f - 24'(step) : 24'd1;
        end
    endtask

    // Receiver: draw a stall length per result, sample on the accepting edge.
    initial begin
        window_t got;
        int      wait_n;
        @(posedge rst_n);
        forever begin
            if (hold_off > 0) begin
                out_stall <= 1'b1;
                repeat (hold_off) @(posedge clk);
                hold_off = 0;
            end
            wait_n = busy_idle ? $urandom_range(0, 10) : 0;
            if (wait_n > 0) begin
                out_stall <= 1'b1;
                repeat (wait_n) @(posedge clk);
            end
            out_stall <= 1'b0;
            do @(posedge clk); while (!(out_valid && !out_stall));
            got.chan = channel_number;
            got.start = start_index;
            got.stop = end_index;
            got.total = window_total;
            got.last = last;
            sb.check_window(got);
        end
    end

    // Stimulus
    initial begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Default settings: zero dispersion gives all-zero starts.
        send_channel(24'd25600, 1'b1);
        send_sweep(3);
        drain();

        // Directed: extremes of frequency, single-channel sweep, imaginary
        // channel at or below zero, channel above the reference.
        write_reg(ddwi_pkg::REG_DM, 24'd1024);
        write_reg(ddwi_pkg::REG_REF, 24'd51200);
        write_reg(ddwi_pkg::REG_TSTEP, 24'd1);
        send_channel(24'd1, 1'b1);
        send_channel(24'hFFFFFF, 1'b1);
        send_channel(24'd100, 1'b0);
        send_channel(24'd200, 1'b1);     // imaginary channel lands on zero
        send_channel(24'd100, 1'b0);
        send_channel(24'd350, 1'b0);     // imaginary channel negative
        send_channel(24'd60000, 1'b0);   // above reference: negative start
        send_channel(24'd40000, 1'b1);
        send_channel(24'd51200, 1'b0);
        send_channel(24'd51100, 1'b1);
        drain();
        write_reg(ddwi_pkg::REG_DM, 24'hFFFFFF);
        write_reg(ddwi_pkg::REG_REF, 24'd1);
        write_reg(ddwi_pkg::REG_TSTEP, 24'hFFFFFF);
        send_channel(24'd2, 1'b0);
        send_channel(24'hFFFFFF, 1'b0);
        send_channel(24'd5000, 1'b1);
        drain();
        write_reg(ddwi_pkg::REG_REF, 24'hFFFFFF);
        write_reg(ddwi_pkg::REG_TSTEP, 24'd1);
        send_channel(24'd1, 1'b0);
        send_channel(24'd2, 1'b0);
        send_channel(24'd3, 1'b1);
        drain();

        // Back pressure: receiver holds off while channels keep coming.
        hold_off = 400;
        send_sweep(12);
        drain();

        // Random phases through several register settings.
        for (int ph = 0; ph < 10; ph++) begin
            write_reg(ddwi_pkg::REG_DM, (ph % 3 == 0) ? 24'($urandom_range(0, 24'hFFFFFF))
                                                      : 24'($urandom_range(0, 8192)));
            write_reg(ddwi_pkg::REG_REF, (ph == 4) ? 24'hFFFFFF
                                                   : 24'($urandom_range(12800, 51200)));
            write_reg(ddwi_pkg::REG_TSTEP, (ph == 5) ? 24'd1
                                                     : 24'($urandom_range(1, 24'hFFFFFF)));
            busy_idle = (ph != 7);
            while (sent < 120 + ph * 100)
                send_sweep(($urandom_range(0, 7) == 0) ? 1 : $urandom_range(2, 40));
            drain();
        end
        busy_idle = 1'b1;

        $display("covered %0d channels and %0d windows across sweeps of 1 to 40 channels",
                 sent, sb.checked);
        $display("settings included register extremes, zero dispersion and long stalls");
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("dispersion_delay_window_indexer test passed");
        else
            $display("dispersion_delay_window_indexer test failed");
        $finish;
    end

    initial begin
        #8ms;
        $display("dispersion_delay_window_indexer test failed");
        $finish;
    end
endmodule
